// ===== rtl/bpc_pkg.sv =====
// Shared types and constants for the barometric pressure compensation block.
// Used by bpc_div_cell, baro_pressure_compensation and the testbench.
`default_nettype none

package bpc_pkg;

  // One divider cell per quotient bit
  localparam int DIV_CELLS = 64;
  // Registers from the accept edge to the result register:
  // 8 front stages, the divider row, 1 sign fix, 2 x 2 multiply, 1 output
  localparam int LATENCY   = DIV_CELLS + 14;
  // Divisor magnitude is at most 2^30
  localparam int REM_W     = 31;

  localparam logic [20:0]        RAW_FULL_SCALE = 21'd1048576;
  localparam logic signed [20:0] TEMP_OFFSET    = 21'sd128000;
  localparam logic [11:0]        SCALE_MUL      = 12'd3125;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_P1    = 3'd0,
    REG_P2    = 3'd1,
    REG_P3    = 3'd2,
    REG_P4    = 3'd3,
    REG_P5    = 3'd4,
    REG_P6    = 3'd5,
    REG_P7    = 3'd6,
    REG_P8_P9 = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [19:0]        raw_pressure;
    logic signed [19:0] fine_temperature;
  } in_word_t;

  typedef struct packed {
    logic [31:0] pressure_q24_8;
    logic        invalid;
  } out_word_t;

  // Word passed from one divider cell to the next
  typedef struct packed {
    logic [REM_W-1:0] rem;     // partial remainder
    logic [63:0]      dq;      // dividend bits left, quotient bits shifted in
    logic [REM_W-1:0] dmag;    // divisor magnitude
    logic             neg;     // quotient sign
    logic             invalid; // divisor was zero
  } div_cell_t;

endpackage

`default_nettype wire

// ===== rtl/bpc_mul64.sv =====
// 64 x 64 multiply keeping the low 64 bits (two's complement wrap), two stages.
// Built from three 32 x 32 partial products. Depends on nothing.
`default_nettype none

module bpc_mul64 (
  input  wire logic        clk,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic      [63:0] p
);

  logic [63:0] ll_r, ll_nxt;
  logic [31:0] lh_r, lh_nxt;
  logic [31:0] hl_r, hl_nxt;
  logic [63:0] p_r, p_nxt;

  // partial products; the high x high term falls off the top
  always_comb begin
    ll_nxt = 64'(a[31:0]) * 64'(b[31:0]);
    lh_nxt = a[31:0] * b[63:32];
    hl_nxt = a[63:32] * b[31:0];
  end

  // recombine
  assign p_nxt = ll_r + {lh_r + hl_r, 32'b0};

  always_ff @(posedge clk) begin
    ll_r <= ll_nxt;
    lh_r <= lh_nxt;
    hl_r <= hl_nxt;
    p_r  <= p_nxt;
  end

  assign p = p_r;

endmodule

`default_nettype wire

// ===== rtl/bpc_div_cell.sv =====
// One restoring-division cell: decides one quotient bit and passes the word on.
// Depends on bpc_pkg.
`default_nettype none

module bpc_div_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire bpc_pkg::div_cell_t in_cell,
  output logic                    out_valid,
  output bpc_pkg::div_cell_t      out_cell
);
  import bpc_pkg::*;

  logic [REM_W:0]   shifted;
  logic [REM_W+1:0] diff;
  logic             borrow;
  div_cell_t        cell_nxt, cell_r;
  logic             valid_r;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted  = {in_cell.rem, in_cell.dq[63]};
    diff     = {1'b0, shifted} - {2'b0, in_cell.dmag};
    borrow   = diff[REM_W+1];
    cell_nxt = in_cell;
    cell_nxt.rem = borrow ? shifted[REM_W-1:0] : diff[REM_W-1:0];
    cell_nxt.dq  = {in_cell.dq[62:0], ~borrow};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign out_valid = valid_r;
  assign out_cell  = cell_r;

endmodule

`default_nettype wire

// ===== rtl/baro_pressure_compensation.sv =====
// Top level of the barometric pressure compensation pipeline.
// Depends on bpc_pkg, bpc_mul64 and bpc_div_cell.
//
//  channel  ports                          direction  handshake
//  input    start, busy, in_word           in         start && !busy
//  result   out_strobe, out_word           out        strobe, one cycle
//  config   cfg_valid, cfg_ready,          in         cfg_valid && cfg_ready
//           cfg_index, cfg_data
//
// One word is taken every cycle; busy stays low. Each result passes the front stages,
// the 64-cell divider row, the sign fix, the multiplies and the output register.
// Reset is synchronous, active low, and clears all valid flags and the calibration registers.
// The receiver cannot stall; results are shown for one cycle only.
// Calibration must be written only while the pipeline is empty; the block does not enforce it.
`default_nettype none

module baro_pressure_compensation (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire bpc_pkg::in_word_t in_word,
  output logic                   out_strobe,
  output bpc_pkg::out_word_t     out_word,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [7:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);
  import bpc_pkg::*;

  // calibration registers
  logic [15:0]        p1_r;
  logic signed [15:0] p2_r, p3_r, p4_r, p5_r, p6_r, p7_r;
  logic [31:0]        p89_r;
  logic signed [15:0] p8, p9;

  // valid flags
  logic [7:0] fv_r;
  logic [4:0] bv_r;
  logic       out_strobe_r;
  logic       acc;

  // front end stages
  logic [19:0]        s0_raw_r;
  logic signed [19:0] s0_t_r;
  logic signed [20:0] s1_a;
  logic signed [41:0] s1_aa_r, s1_aa_nxt;
  logic signed [36:0] s1_ap5_r, s1_ap5_nxt, s1_ap2_r, s1_ap2_nxt;
  logic [20:0]        s1_p_r, s1_p_nxt;
  logic signed [57:0] s2_aap6_r, s2_aap6_nxt, s2_aap3_r, s2_aap3_nxt;
  logic signed [36:0] s2_ap5_r, s2_ap2_r;
  logic [20:0]        s2_p_r;
  logic signed [57:0] s3_b_r, s3_b_nxt;
  logic signed [50:0] s3_y_r, s3_y_nxt;
  logic [20:0]        s3_p_r;
  logic [47:0]        s4_yl_r, s4_yl_nxt;
  logic signed [35:0] s4_yh_r, s4_yh_nxt;
  logic signed [58:0] s4_num_r, s4_num_nxt;
  logic [63:0]        s5_prod;
  logic signed [30:0] s5_d_r, s5_d_nxt;
  logic [43:0]        s5_nl_r, s5_nl_nxt;
  logic signed [39:0] s5_nh_r, s5_nh_nxt;
  logic [63:0]        s6_n_r, s6_n_nxt;
  logic signed [30:0] s6_d_r;
  div_cell_t          s7_r, s7_nxt;

  // divider row
  logic      cv [0:DIV_CELLS];
  div_cell_t cw [0:DIV_CELLS];

  // back end
  logic [63:0] q_r, q_nxt;
  logic        qi_r;
  logic [63:0] ps, psq, p8p, p9psq;
  logic [63:0] q1_r, q2_r, q3_r, q4_r;
  logic        i1_r, i2_r, i3_r, i4_r;
  logic [63:0] b8_r, b8a_r, b8_nxt;
  logic [63:0] fin, fin_sh;
  out_word_t   out_r, out_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;
  assign p8        = $signed(p89_r[15:0]);
  assign p9        = $signed(p89_r[31:16]);

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r  <= '0;
      p2_r  <= '0;
      p3_r  <= '0;
      p4_r  <= '0;
      p5_r  <= '0;
      p6_r  <= '0;
      p7_r  <= '0;
      p89_r <= '0;
    end else if (cfg_valid && cfg_ready && (cfg_index[7:3] == 5'd0)) begin
      case (cfg_reg_t'(cfg_index[2:0]))
        REG_P1:    p1_r  <= cfg_data[15:0];
        REG_P2:    p2_r  <= $signed(cfg_data[15:0]);
        REG_P3:    p3_r  <= $signed(cfg_data[15:0]);
        REG_P4:    p4_r  <= $signed(cfg_data[15:0]);
        REG_P5:    p5_r  <= $signed(cfg_data[15:0]);
        REG_P6:    p6_r  <= $signed(cfg_data[15:0]);
        REG_P7:    p7_r  <= $signed(cfg_data[15:0]);
        REG_P8_P9: p89_r <= cfg_data;
        default:   p89_r <= p89_r;
      endcase
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r         <= '0;
      bv_r         <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      fv_r         <= {fv_r[6:0], acc};
      bv_r         <= {bv_r[3:0], cv[DIV_CELLS]};
      out_strobe_r <= bv_r[4];
    end
  end

  // stage 1: temperature offset, square and linear products, pressure below full scale
  always_comb begin
    s1_a       = $signed({s0_t_r[19], s0_t_r}) - TEMP_OFFSET;
    s1_aa_nxt  = s1_a * s1_a;
    s1_ap5_nxt = s1_a * p5_r;
    s1_ap2_nxt = s1_a * p2_r;
    s1_p_nxt   = RAW_FULL_SCALE - {1'b0, s0_raw_r};
  end

  // stage 2: square terms times calibration
  always_comb begin
    s2_aap6_nxt = s1_aa_r * p6_r;
    s2_aap3_nxt = s1_aa_r * p3_r;
  end

  // stage 3: offset sum and divisor before scaling
  always_comb begin
    s3_b_nxt = s2_aap6_r + (58'(s2_ap5_r) <<< 17) + (58'(p4_r) <<< 35);
    s3_y_nxt = 51'(s2_aap3_r >>> 8) + (51'(s2_ap2_r) <<< 12) + (51'sd1 <<< 47);
  end

  // stage 4: divisor times p1 in two halves, numerator
  always_comb begin
    s4_yl_nxt  = 48'(s3_y_r[31:0]) * 48'(p1_r);
    s4_yh_nxt  = $signed(s3_y_r[50:32]) * $signed({1'b0, p1_r});
    s4_num_nxt = $signed({7'b0, s3_p_r, 31'b0}) - 59'(s3_b_r);
  end

  // stage 5: final divisor, numerator times scale in two halves
  always_comb begin
    s5_prod   = 64'(s4_yl_r) + {s4_yh_r[31:0], 32'b0};
    s5_d_nxt  = $signed(s5_prod[63:33]);
    s5_nl_nxt = 44'(s4_num_r[31:0]) * 44'(SCALE_MUL);
    s5_nh_nxt = $signed(s4_num_r[58:32]) * $signed({1'b0, SCALE_MUL});
  end

  // stage 6: wrapped numerator
  assign s6_n_nxt = 64'(s5_nl_r) + {s5_nh_r[31:0], 32'b0};

  // stage 7: magnitudes and signs for the divider
  always_comb begin
    s7_nxt.rem     = '0;
    s7_nxt.dq      = s6_n_r[63] ? (64'd0 - s6_n_r) : s6_n_r;
    s7_nxt.dmag    = s6_d_r[30] ? (31'd0 - s6_d_r) : s6_d_r;
    s7_nxt.neg     = s6_n_r[63] ^ s6_d_r[30];
    s7_nxt.invalid = (s6_d_r == 31'sd0);
  end

  always_ff @(posedge clk) begin
    s0_raw_r  <= in_word.raw_pressure;
    s0_t_r    <= in_word.fine_temperature;
    s1_aa_r   <= s1_aa_nxt;
    s1_ap5_r  <= s1_ap5_nxt;
    s1_ap2_r  <= s1_ap2_nxt;
    s1_p_r    <= s1_p_nxt;
    s2_aap6_r <= s2_aap6_nxt;
    s2_aap3_r <= s2_aap3_nxt;
    s2_ap5_r  <= s1_ap5_r;
    s2_ap2_r  <= s1_ap2_r;
    s2_p_r    <= s1_p_r;
    s3_b_r    <= s3_b_nxt;
    s3_y_r    <= s3_y_nxt;
    s3_p_r    <= s2_p_r;
    s4_yl_r   <= s4_yl_nxt;
    s4_yh_r   <= s4_yh_nxt;
    s4_num_r  <= s4_num_nxt;
    s5_d_r    <= s5_d_nxt;
    s5_nl_r   <= s5_nl_nxt;
    s5_nh_r   <= s5_nh_nxt;
    s6_n_r    <= s6_n_nxt;
    s6_d_r    <= s5_d_r;
    s7_r      <= s7_nxt;
  end

  // divider row, one quotient bit per cell
  assign cv[0] = fv_r[7];
  assign cw[0] = s7_r;

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    bpc_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (cv[i]),
      .in_cell  (cw[i]),
      .out_valid(cv[i+1]),
      .out_cell (cw[i+1])
    );
  end

  // signed quotient
  assign q_nxt = cw[DIV_CELLS].neg ? (64'd0 - cw[DIV_CELLS].dq) : cw[DIV_CELLS].dq;

  // second-order correction products
  assign ps = $signed(q_r) >>> 13;

  bpc_mul64 u_mul_sq (
    .clk(clk),
    .a  (ps),
    .b  (ps),
    .p  (psq)
  );

  bpc_mul64 u_mul_p8 (
    .clk(clk),
    .a  (q_r),
    .b  (64'(p8)),
    .p  (p8p)
  );

  bpc_mul64 u_mul_p9 (
    .clk(clk),
    .a  (psq),
    .b  (64'(p9)),
    .p  (p9psq)
  );

  assign b8_nxt = $signed(p8p) >>> 19;

  // final sum, scale to Q24.8, invalid forces zero
  always_comb begin
    fin    = q4_r + 64'($signed(p9psq) >>> 25) + b8a_r;
    fin_sh = 64'($signed(fin) >>> 8) + (64'(p7_r) <<< 4);
    out_nxt.pressure_q24_8 = i4_r ? 32'd0 : fin_sh[31:0];
    out_nxt.invalid        = i4_r;
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    qi_r  <= cw[DIV_CELLS].invalid;
    q1_r  <= q_r;
    q2_r  <= q1_r;
    q3_r  <= q2_r;
    q4_r  <= q3_r;
    i1_r  <= qi_r;
    i2_r  <= i1_r;
    i3_r  <= i2_r;
    i4_r  <= i3_r;
    b8_r  <= b8_nxt;
    b8a_r <= b8_r;
    out_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_r;

  // every taken word gives one result a fixed time later
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_strobe)
    else $error("result missing after accepted word");

  // no result without a word taken
  a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LATENCY))
    else $error("result without accepted word");

  // a zero divisor gives zero pressure
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.invalid) |-> (out_word.pressure_q24_8 == 32'd0))
    else $error("invalid result with nonzero pressure");

endmodule

`default_nettype wire

// ===== test/tb_baro_pressure_compensation.sv =====
// Testbench for baro_pressure_compensation: random and directed pressure words
// checked against a 64-bit integer compensation predictor. Depends on bpc_pkg and baro_pressure_compensation.
`default_nettype none

module tb_baro_pressure_compensation;
  import bpc_pkg::*;

  localparam int DRAIN = LATENCY + 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_word = '0;
  logic out_strobe;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  baro_pressure_compensation dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // calibration copy
  logic [15:0] cal_p[1:7];
  logic [31:0] cal_p89;

  in_word_t  pending_words[$];
  out_word_t expected_pressures[$];
  int        fail_count = 0;
  int        idle_pct = 0;
  bit        cfg_go = 0;
  logic [7:0]  cfg_idx_req;
  logic [31:0] cfg_dat_req;

  function automatic out_word_t compensate(in_word_t w);
    logic signed [63:0] a, b, p, ps, p1, p2, p3, p4, p5, p6, p7, p8, p9, q;
    out_word_t r;
    p1 = {48'd0, cal_p[1]};
    p2 = 64'(signed'(cal_p[2])); p3 = 64'(signed'(cal_p[3]));
    p4 = 64'(signed'(cal_p[4])); p5 = 64'(signed'(cal_p[5]));
    p6 = 64'(signed'(cal_p[6])); p7 = 64'(signed'(cal_p[7]));
    p8 = 64'(signed'(cal_p89[15:0])); p9 = 64'(signed'(cal_p89[31:16]));
    a = 64'(w.fine_temperature) - 64'sd128000;
    b = a * a * p6;
    b = b + ((a * p5) <<< 17);
    b = b + (p4 <<< 35);
    a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
    a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
    if (a == 0) begin
      r.pressure_q24_8 = '0;
      r.invalid = 1'b1;
      return r;
    end
    p = 64'sd1048576 - $signed({44'd0, w.raw_pressure});
    q = ((p <<< 31) - b) * 64'sd3125;
    // truncating division; min / -1 wraps
    if (q == {1'b1, 63'd0} && a == -64'sd1) p = q;
    else p = q / a;
    ps = p >>> 13;
    a = (p9 * ps * ps) >>> 25;
    b = (p8 * p) >>> 19;
    p = ((p + a + b) >>> 8) + (p7 <<< 4);
    r.pressure_q24_8 = p[31:0];
    r.invalid = 1'b0;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_pressures.push_back(compensate(in_word));
        pending_words.pop_front();
      end
      if ((pending_words.size() > 0) && ($urandom_range(99) >= idle_pct)) begin
        start <= 1'b1;
        in_word <= pending_words[0];
      end else begin
        start <= 1'b0;
      end
    end
    // config channel
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_P8_P9) cal_p89 = cfg_data;
      else if (cfg_index < 8) cal_p[cfg_index[2:0] + 1] = cfg_data[15:0];
      cfg_valid <= 1'b0;
      cfg_go = 0;
    end else if (cfg_go) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_req;
      cfg_data <= cfg_dat_req;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_strobe) begin
      if (expected_pressures.size() == 0) begin
        $error("unexpected word: pressure_q24_8 %h invalid %b",
               out_word.pressure_q24_8, out_word.invalid);
        fail_count++;
      end else begin
        e = expected_pressures.pop_front();
        if (e.pressure_q24_8 !== out_word.pressure_q24_8) begin
          $error("pressure_q24_8 expected %h actual %h", e.pressure_q24_8,
                 out_word.pressure_q24_8);
          fail_count++;
        end
        if (e.invalid !== out_word.invalid) begin
          $error("invalid expected %b actual %b", e.invalid, out_word.invalid);
          fail_count++;
        end
      end
    end
  end

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_idx_req = idx;
    cfg_dat_req = val;
    cfg_go = 1;
    while (cfg_go) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic wait_empty();
    while (pending_words.size() != 0 || start || expected_pressures.size() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // typical datasheet-like calibration with small random spread
  task automatic load_typical();
    write_reg(REG_P1, 16'd36477 + $urandom_range(2000));
    write_reg(REG_P2, -16'sd10685 + $urandom_range(500));
    write_reg(REG_P3, 16'd3024);
    write_reg(REG_P4, 16'd2855 + $urandom_range(200));
    write_reg(REG_P5, 16'd140);
    write_reg(REG_P6, -16'sd7);
    write_reg(REG_P7, 16'd15500);
    write_reg(REG_P8_P9, {16'd6000, -16'sd14600});
  endtask

  task automatic load_random();
    for (int i = 0; i < 8; i++) write_reg(i[7:0], $urandom);
  endtask

  function automatic in_word_t rand_word();
    in_word_t w;
    w.raw_pressure = 20'($urandom);
    w.fine_temperature = 20'($urandom);
    if ($urandom_range(3) != 0) begin
      // realistic range
      w.raw_pressure = 20'(250000 + $urandom_range(200000));
      w.fine_temperature = 20'(80000 + $urandom_range(80000));
    end
    return w;
  endfunction

  initial begin
    in_word_t w;
    int pcts[4] = '{0, 57, 0, 37};
    for (int i = 1; i <= 7; i++) cal_p[i] = '0;
    cal_p89 = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // all-zero calibration: divisor zero
    w = '0; pending_words.push_back(w);
    w.raw_pressure = '1; w.fine_temperature = 20'h7FFFF; pending_words.push_back(w);
    wait_empty();
    // write extremes, then out-of-range index
    write_reg(REG_P1, 16'hFFFF);
    for (int i = 1; i < 7; i++) write_reg(i[7:0], 16'h8000);
    write_reg(REG_P8_P9, 32'h7FFF_8000);
    write_reg(8'd200, 32'hFFFF_FFFF);
    w.raw_pressure = '0; w.fine_temperature = 20'h80000; pending_words.push_back(w);
    w.raw_pressure = '1; w.fine_temperature = 20'h7FFFF; pending_words.push_back(w);
    w.raw_pressure = 20'd1; w.fine_temperature = 20'd0; pending_words.push_back(w);
    wait_empty();
    for (int i = 0; i < 7; i++) write_reg(i[7:0], 16'h7FFF);
    write_reg(REG_P8_P9, 32'h8000_7FFF);
    for (int i = 0; i < 8; i++) pending_words.push_back(rand_word());
    wait_empty();
    load_typical();
    for (int i = 0; i < 8; i++) pending_words.push_back(rand_word());
    wait_empty();
    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = pcts[ph % 4];
      if (ph % 2) load_random(); else load_typical();
      for (int i = 0; i < 125; i++) pending_words.push_back(rand_word());
      wait_empty();
    end
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

`default_nettype wire
